>>> rtl/pcvf_pkg.sv
// ----------------------------------------------------------------------------
// pcvf_pkg
// Shared widths, constants and types of the plane-cut volume fraction core.
// ----------------------------------------------------------------------------
package pcvf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NRM_W     = 18;
    localparam int OFS_W     = 19;
    localparam int OUT_W     = 17;

    // Bias of 1e-4, rounded up to a whole fraction unit.
    localparam int EPS_UNITS = ((1 << FRAC_BITS) + 9999) / 10000;

    localparam int ALPHA_W = OFS_W + 2;       // folded offset, signed
    localparam int SUM_W   = NRM_W + 2;       // sum of three magnitudes
    localparam int NB_W    = NRM_W;           // biased magnitude
    localparam int BASE_W  = NRM_W + 1;       // cube operands, below the sum
    localparam int SQ_W    = 2 * BASE_W;
    localparam int CUBE_W  = 3 * BASE_W;
    localparam int NUM_W   = CUBE_W + 3;      // signed numerator
    localparam int PROD_W  = 3 * NB_W;
    localparam int DEN_W   = PROD_W + 3;      // six times the product
    localparam int Q_W     = FRAC_BITS + 1;   // quotient with a rounding bit
    localparam int RES_W   = (Q_W > OUT_W) ? Q_W : OUT_W;

    localparam logic [RES_W-1:0] ONE = RES_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_ONE,
        CLS_CALC
    } cls_t;

    typedef struct packed {
        cls_t                        cls;
        logic [6:0][BASE_W-1:0]      base;
        logic [2*NB_W-1:0]           nb01;
        logic [NB_W-1:0]             nb2;
    } prep_t;

    typedef struct packed {
        cls_t               cls;
        logic [DEN_W-1:0]   rem;
        logic [DEN_W-1:0]   den;
    } div_in_t;

endpackage

>>> rtl/pcvf_prep.sv
// ----------------------------------------------------------------------------
// pcvf_prep
// Folds the normal into the positive octant, classifies empty and full cells
// and forms the seven cube operands and the first denominator product.
// ----------------------------------------------------------------------------
module pcvf_prep
    import pcvf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [NRM_W-1:0]  normal_x,
    input  logic signed [NRM_W-1:0]  normal_y,
    input  logic signed [NRM_W-1:0]  normal_z,
    input  logic signed [OFS_W-1:0]  plane_offset,
    output logic                     out_valid,
    input  logic                     out_ready,
    output prep_t                    out_data
);

    logic [1:0] v_reg;
    logic [1:0] en;

    logic signed [NRM_W-1:0]   nrm [3];
    logic signed [ALPHA_W-1:0] nw;
    logic signed [ALPHA_W-1:0] alpha;
    logic [SUM_W-1:0]          s;
    logic [NB_W-1:0]           mag [3];
    cls_t                      cls_a;

    cls_t                      a_cls_reg;
    logic [BASE_W-1:0]         a_alpha_reg;
    logic [2:0][NB_W-1:0]      a_nb_reg;

    logic [SUM_W-1:0]          sb;
    logic signed [ALPHA_W-1:0] as_v;
    logic signed [ALPHA_W-1:0] dv;
    logic signed [ALPHA_W-1:0] ev;
    prep_t                     b_next;
    prep_t                     b_reg;

    always_comb
    begin
        en[1] = !v_reg[1] || out_ready;
        en[0] = !v_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[1];
    assign out_data  = b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    // Stage A: fold negative components into the offset.
    always_comb
    begin
        nrm[0] = normal_x;
        nrm[1] = normal_y;
        nrm[2] = normal_z;
        alpha  = ALPHA_W'(plane_offset);
        s      = '0;
        nw     = '0;
        for (int i = 0; i < 3; i++)
        begin
            nw = ALPHA_W'(nrm[i]);
            if (nw < 0)
            begin
                alpha = alpha - nw;
                nw    = -nw;
            end
            mag[i] = nw[NB_W-1:0];
            s      = s + SUM_W'(mag[i]);
        end
        if (alpha <= 0)
        begin
            cls_a = CLS_ZERO;
        end
        else if (alpha >= $signed({1'b0, s}))
        begin
            cls_a = CLS_ONE;
        end
        else
        begin
            cls_a = CLS_CALC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_cls_reg   <= cls_a;
            a_alpha_reg <= alpha[BASE_W-1:0];
            for (int i = 0; i < 3; i++)
            begin
                a_nb_reg[i] <= mag[i] + NB_W'(EPS_UNITS);
            end
        end
    end

    // Stage B: positive parts of the inclusion-exclusion terms.
    always_comb
    begin
        sb   = SUM_W'(a_nb_reg[0]) + SUM_W'(a_nb_reg[1]) + SUM_W'(a_nb_reg[2]);
        as_v = $signed(ALPHA_W'(a_alpha_reg));
        dv   = '0;
        ev   = '0;
        b_next.cls     = a_cls_reg;
        b_next.base[0] = a_alpha_reg;
        for (int i = 0; i < 3; i++)
        begin
            dv = as_v - $signed(ALPHA_W'(a_nb_reg[i]));
            ev = as_v - $signed(ALPHA_W'(sb)) + $signed(ALPHA_W'(a_nb_reg[i]));
            b_next.base[1+i] = (dv > 0) ? dv[BASE_W-1:0] : '0;
            b_next.base[4+i] = (ev > 0) ? ev[BASE_W-1:0] : '0;
        end
        b_next.nb01 = (2*NB_W)'(a_nb_reg[0]) * (2*NB_W)'(a_nb_reg[1]);
        b_next.nb2  = a_nb_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_reg <= b_next;
        end
    end

endmodule

>>> rtl/pcvf_cube.sv
// ----------------------------------------------------------------------------
// pcvf_cube
// Cubes the seven operands, sums the cubic numerator, forms the denominator
// and settles numerators that fall outside the open unit interval.
// ----------------------------------------------------------------------------
module pcvf_cube
    import pcvf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  prep_t    in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output div_in_t  out_data
);

    localparam int NS = 5;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // Stage C
    cls_t                       c_cls_reg;
    logic [6:0][SQ_W-1:0]       c_sq_reg;
    logic [6:0][BASE_W-1:0]     c_b_reg;
    logic [2*NB_W-1:0]          c_dlo_reg;
    logic [2*NB_W-1:0]          c_dhi_reg;
    // Stage D
    cls_t                       d_cls_reg;
    logic [6:0][2*BASE_W-1:0]   d_cl_reg;
    logic [6:0][2*BASE_W-1:0]   d_ch_reg;
    logic [PROD_W-1:0]          d_prod_reg;
    // Stage E
    cls_t                       e_cls_reg;
    logic [6:0][CUBE_W-1:0]     e_cube_reg;
    logic [DEN_W-1:0]           e_den_reg;
    // Stage F
    cls_t                       f_cls_reg;
    logic [NUM_W-1:0]           f_num_reg;
    logic [DEN_W-1:0]           f_den_reg;
    // Stage G
    div_in_t                    g_next;
    div_in_t                    g_reg;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c_cls_reg <= in_data.cls;
            for (int i = 0; i < 7; i++)
            begin
                c_sq_reg[i] <= SQ_W'(in_data.base[i]) * SQ_W'(in_data.base[i]);
                c_b_reg[i]  <= in_data.base[i];
            end
            c_dlo_reg <= (2*NB_W)'(in_data.nb01[NB_W-1:0]) * (2*NB_W)'(in_data.nb2);
            c_dhi_reg <= (2*NB_W)'(in_data.nb01[2*NB_W-1:NB_W]) * (2*NB_W)'(in_data.nb2);
        end
        if (en[1])
        begin
            d_cls_reg <= c_cls_reg;
            for (int i = 0; i < 7; i++)
            begin
                // The square is split in two halves to keep each product narrow.
                d_cl_reg[i] <= (2*BASE_W)'(c_sq_reg[i][BASE_W-1:0])
                               * (2*BASE_W)'(c_b_reg[i]);
                d_ch_reg[i] <= (2*BASE_W)'(c_sq_reg[i][SQ_W-1:BASE_W])
                               * (2*BASE_W)'(c_b_reg[i]);
            end
            d_prod_reg <= (PROD_W'(c_dhi_reg) << NB_W) + PROD_W'(c_dlo_reg);
        end
        if (en[2])
        begin
            e_cls_reg <= d_cls_reg;
            for (int i = 0; i < 7; i++)
            begin
                e_cube_reg[i] <= (CUBE_W'(d_ch_reg[i]) << BASE_W) + CUBE_W'(d_cl_reg[i]);
            end
            e_den_reg <= (DEN_W'(d_prod_reg) << 2) + (DEN_W'(d_prod_reg) << 1);
        end
        if (en[3])
        begin
            f_cls_reg <= e_cls_reg;
            f_num_reg <= NUM_W'(e_cube_reg[0])
                         - NUM_W'(e_cube_reg[1]) - NUM_W'(e_cube_reg[2])
                         - NUM_W'(e_cube_reg[3])
                         + NUM_W'(e_cube_reg[4]) + NUM_W'(e_cube_reg[5])
                         + NUM_W'(e_cube_reg[6]);
            f_den_reg <= e_den_reg;
        end
        if (en[4])
        begin
            g_reg <= g_next;
        end
    end

    always_comb
    begin
        g_next.cls = f_cls_reg;
        g_next.rem = f_num_reg[DEN_W-1:0];
        g_next.den = f_den_reg;
        if (f_cls_reg == CLS_CALC)
        begin
            if (f_num_reg[NUM_W-1] || (f_num_reg == '0))
            begin
                g_next.cls = CLS_ZERO;
            end
            else if (f_num_reg >= NUM_W'(f_den_reg))
            begin
                g_next.cls = CLS_ONE;
            end
        end
    end

endmodule

>>> rtl/pcvf_div.sv
// ----------------------------------------------------------------------------
// pcvf_div
// Restoring division pipeline, one quotient bit per stage, followed by
// round-to-nearest and selection of the empty and full results.
// ----------------------------------------------------------------------------
module pcvf_div
    import pcvf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  div_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  volume_fraction
);

    localparam int NS = Q_W + 1;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    cls_t                        cls_reg [Q_W];
    logic [Q_W-1:0][DEN_W-1:0]   rem_reg;
    logic [Q_W-1:0][DEN_W-1:0]   den_reg;
    logic [Q_W-1:0][Q_W-1:0]     q_reg;

    logic [Q_W-1:0][DEN_W-1:0]   rem_next;
    logic [Q_W-1:0][Q_W-1:0]     q_next;
    logic [DEN_W:0]              t;
    logic [DEN_W-1:0]            src_rem;
    logic [DEN_W-1:0]            src_den;
    logic [Q_W-1:0]              src_q;

    logic [Q_W:0]                rnd;
    logic [RES_W-1:0]            res;
    logic [RES_W-1:0]            res_reg;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready        = en[0];
    assign out_valid       = v_reg[NS-1];
    assign volume_fraction = res_reg[OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Each stage doubles the remainder and subtracts the divisor where it fits.
    always_comb
    begin
        t       = '0;
        src_rem = '0;
        src_den = '0;
        src_q   = '0;
        for (int k = 0; k < Q_W; k++)
        begin
            if (k == 0)
            begin
                src_rem = in_data.rem;
                src_den = in_data.den;
                src_q   = '0;
            end
            else
            begin
                src_rem = rem_reg[k-1];
                src_den = den_reg[k-1];
                src_q   = q_reg[k-1];
            end
            t = {src_rem, 1'b0};
            if (t >= {1'b0, src_den})
            begin
                t           = t - {1'b0, src_den};
                q_next[k]   = {src_q[Q_W-2:0], 1'b1};
            end
            else
            begin
                q_next[k]   = {src_q[Q_W-2:0], 1'b0};
            end
            rem_next[k] = t[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < Q_W; k++)
        begin
            if (en[k])
            begin
                cls_reg[k] <= (k == 0) ? in_data.cls : cls_reg[(k == 0) ? 0 : k - 1];
                den_reg[k] <= (k == 0) ? in_data.den : den_reg[(k == 0) ? 0 : k - 1];
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
        if (en[NS-1])
        begin
            res_reg <= res;
        end
    end

    always_comb
    begin
        rnd = ({1'b0, q_reg[Q_W-1]} + (Q_W+1)'(1)) >> 1;
        res = RES_W'(rnd);
        if (res > ONE)
        begin
            res = ONE;
        end
        case (cls_reg[Q_W-1])
            CLS_ZERO: res = '0;
            CLS_ONE:  res = ONE;
            default:  ;
        endcase
    end

endmodule

>>> rtl/plane_cut_volume_fraction_core.sv
// ----------------------------------------------------------------------------
// plane_cut_volume_fraction_core
// Volume fraction of the unit cube below a plane, one item per clock unless stalled.
// ----------------------------------------------------------------------------
// The path from input accept to result valid runs through 25 register stages
// (2 fold, 5 cube and numerator, 17 quotient-bit stages, 1 rounding).
// Throughput: one item per cycle while out_ready is high; every stage holds its
// item under a stall and empty stages keep filling while the result waits.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module plane_cut_volume_fraction_core
    import pcvf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [NRM_W-1:0]  normal_x,
    input  logic signed [NRM_W-1:0]  normal_y,
    input  logic signed [NRM_W-1:0]  normal_z,
    input  logic signed [OFS_W-1:0]  plane_offset,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OUT_W-1:0]         volume_fraction
);

    prep_t    prep_data;
    logic     prep_valid;
    logic     prep_ready;
    div_in_t  cube_data;
    logic     cube_valid;
    logic     cube_ready;

    pcvf_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .plane_offset (plane_offset),
        .out_valid    (prep_valid),
        .out_ready    (prep_ready),
        .out_data     (prep_data)
    );

    pcvf_cube u_cube (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (cube_valid),
        .out_ready (cube_ready),
        .out_data  (cube_data)
    );

    pcvf_div u_div (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (cube_valid),
        .in_ready        (cube_ready),
        .in_data         (cube_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .volume_fraction (volume_fraction)
    );

    // The input side stalls only when the whole pipeline is full and blocked.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a blocked result");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (RES_W'(volume_fraction) <= ONE))
        else $error("volume fraction above one");

    // An item in the front stage cannot be dropped while the next one is blocked.
    a_prep_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (prep_valid && !prep_ready) |=> prep_valid)
        else $error("fold stage lost an item");

endmodule
